### src/rte_pkg.sv
// Package for the report trigger engine: codes, register map, result type, reason table.
package rte_pkg;

    localparam int unsigned DefMaxEntries = 16;
    localparam int unsigned ResultLimit   = 64;
    localparam int unsigned CntW          = 7;
    localparam int unsigned TimeW         = 48;

    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_GI     = 2'd2;

    localparam logic [1:0] CAUSE_CHANGE    = 2'd0;
    localparam logic [1:0] CAUSE_INTEGRITY = 2'd1;
    localparam logic [1:0] CAUSE_GI        = 2'd2;

    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_OPTIONS   = 3'd1;
    localparam logic [2:0] REG_INTEGRITY = 3'd2;
    localparam logic [2:0] REG_BUFTIME   = 3'd3;
    localparam logic [2:0] REG_COUNT     = 3'd4;
    localparam logic [2:0] REG_REASON    = 3'd5;

    localparam logic [1:0] WHY_NONE    = 2'd0;
    localparam logic [1:0] WHY_QUALITY = 2'd1;
    localparam logic [1:0] WHY_VALUE   = 2'd2;
    localparam logic [1:0] WHY_UPDATED = 2'd3;

    localparam logic [5:0] BIT_VALUE        = 6'd2;
    localparam logic [5:0] BIT_QUALITY      = 6'd4;
    localparam logic [5:0] BIT_UPDATE       = 6'd8;
    localparam logic [5:0] REASON_INTEGRITY = 6'd16;
    localparam logic [5:0] REASON_GI        = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_SCAN,
        ST_DRAIN
    } rte_state_t;

    typedef struct packed {
        logic [5:0]  reason;
        logic [4:0]  idx;
        logic [47:0] etime;
        logic [15:0] seq;
        logic [1:0]  cause;
        logic        kind;
    } rte_result_t;

    function automatic logic [5:0] change_reason_bits(input logic [1:0] flag);
        logic [5:0] r;
        unique case (flag)
            WHY_NONE:    r = 6'd0;
            WHY_QUALITY: r = BIT_QUALITY;
            WHY_VALUE:   r = BIT_VALUE;
            default:     r = BIT_UPDATE;
        endcase
        return r;
    endfunction

endpackage

### src/report_trigger_engine.sv
// Report trigger engine: event intake, entry flag memory and report sequencer.
//
// Usage: events arrive on the s_ stream (tuser = mode; tdata = entry_index,
// change_reason, now_ms). Value updates and GI requests are absorbed and
// produce nothing. A tick may start up to two reports (GI then integrity,
// or a lone GI, integrity or change report). Each report is a header request
// followed by entry requests on the m_ stream; tlast marks the final request
// caused by the tick. At most 64 requests leave per tick.
// Scan: the sequencer walks the entry flag memory one entry per cycle while
// the holding register can advance; the registered read of the flag memory
// sets this pace.
// One result waits in a holding register so tlast can be set on it; a
// second sits in the output register. When m_tready stays low the sequencer
// holds and s_tready stays low until the tick's requests are all issued.
// Reset clears the control registers and flags; the first enabled tick always
// sends an integrity report when integrity reports are allowed and the period is nonzero.
// Configuration uses the APB port; register i sits at byte address 4*i.
module report_trigger_engine #(
    parameter int unsigned MAX_ENTRIES = rte_pkg::DefMaxEntries
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] entry_index, [6:5] change_reason, [54:7] now_ms, [55] zero
    input  logic [55:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] sequence_number, [63:16] entry_time, [68:64] item_index,
    // [74:69] reason_bits, [79:75] zero
    output logic [79:0] m_tdata,
    // [0] kind, [2:1] cause
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [4:0] MaxEnt5 = 5'(MAX_ENTRIES);

    // configuration
    logic        enable_reg;
    logic [1:0]  options_reg;
    logic [31:0] period_reg;
    logic [31:0] buftime_reg;
    logic [4:0]  count_reg;
    logic        incl_reason_reg;

    // report state
    logic                     change_pending_reg;
    logic                     gi_pending_reg;
    logic [47:0]              deadline_reg;
    logic [47:0]              next_int_reg;
    logic [15:0]              seq_reg;
    logic [47:0]              toe_reg;
    logic [MAX_ENTRIES-1:0]   flag_valid_reg;
    logic [1:0]               flag_mem [MAX_ENTRIES];

    // sequencer
    rte_pkg::rte_state_t state_reg, state_next;
    logic [1:0]              cause_reg;
    logic                    rem_int_reg;
    logic [rte_pkg::CntW-1:0] cnt_reg;
    logic [4:0]              scan_idx_reg;
    logic [4:0]              p_idx_reg;
    logic                    p_valid_reg;
    logic [1:0]              rd_data_reg;
    logic                    rd_valid_reg;

    logic                    held_valid_reg;
    rte_pkg::rte_result_t    held_reg;
    logic                    m_tvalid_reg;
    logic                    m_tlast_reg;
    rte_pkg::rte_result_t    out_reg;

    // input unpack
    logic [1:0]  in_mode;
    logic [4:0]  in_idx;
    logic [1:0]  in_reason;
    logic [47:0] in_now;
    assign in_mode   = s_tuser;
    assign in_idx    = s_tdata[4:0];
    assign in_reason = s_tdata[6:5];
    assign in_now    = s_tdata[54:7];

    logic [4:0] n_use;
    assign n_use = (count_reg > MaxEnt5) ? MaxEnt5 : count_reg;

    logic in_acc, cfg_wr, can_push, adv;
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign can_push = !m_tvalid_reg || m_tready;
    assign adv      = !held_valid_reg || can_push;

    logic do_gi, do_int, do_chg, tick_go, upd_ok;
    assign do_gi   = options_reg[1] && gi_pending_reg;
    assign do_int  = options_reg[0] && (period_reg != 32'd0) && (in_now >= next_int_reg);
    assign do_chg  = change_pending_reg && (in_now >= deadline_reg) && !do_gi && !do_int;
    assign tick_go = in_acc && enable_reg && (in_mode == rte_pkg::MODE_TICK)
                     && (do_gi || do_int || do_chg);
    assign upd_ok  = in_acc && enable_reg && (in_mode == rte_pkg::MODE_UPDATE)
                     && (in_idx < n_use);

    logic [1:0] flag_cur;
    assign flag_cur = rd_valid_reg ? rd_data_reg : rte_pkg::WHY_NONE;

    logic [AW-1:0] wr_addr, rd_addr;
    assign wr_addr = in_idx[AW-1:0];
    assign rd_addr = scan_idx_reg[AW-1:0];

    // sequencer control
    logic                 emit_en, rd_en, rpt_end, drain_push, hdr_go, emit_take, push_held;
    rte_pkg::rte_result_t emit_res;
    logic [5:0]           raw_reason;

    always_comb begin
        state_next = state_reg;
        emit_en    = 1'b0;
        emit_res   = '0;
        rd_en      = 1'b0;
        rpt_end    = 1'b0;
        drain_push = 1'b0;
        hdr_go     = 1'b0;
        raw_reason = '0;
        s_tready   = (state_reg == rte_pkg::ST_IDLE);
        unique case (state_reg)
            rte_pkg::ST_IDLE: begin
                if (tick_go) begin
                    state_next = rte_pkg::ST_HDR;
                end
            end
            rte_pkg::ST_HDR: begin
                if (adv) begin
                    hdr_go         = 1'b1;
                    emit_en        = 1'b1;
                    emit_res.kind  = 1'b0;
                    emit_res.cause = cause_reg;
                    emit_res.seq   = seq_reg;
                    emit_res.etime = toe_reg;
                    state_next     = rte_pkg::ST_SCAN;
                end
            end
            rte_pkg::ST_SCAN: begin
                if (adv) begin
                    if (cause_reg == rte_pkg::CAUSE_GI) begin
                        raw_reason = rte_pkg::REASON_GI;
                    end else if (cause_reg == rte_pkg::CAUSE_INTEGRITY) begin
                        raw_reason = rte_pkg::REASON_INTEGRITY;
                    end else begin
                        raw_reason = rte_pkg::change_reason_bits(flag_cur);
                    end
                    if (p_valid_reg && ((cause_reg != rte_pkg::CAUSE_CHANGE)
                                        || (flag_cur != rte_pkg::WHY_NONE))) begin
                        emit_en         = 1'b1;
                        emit_res.kind   = 1'b1;
                        emit_res.cause  = cause_reg;
                        emit_res.seq    = seq_reg;
                        emit_res.etime  = toe_reg;
                        emit_res.idx    = p_idx_reg;
                        emit_res.reason = incl_reason_reg ? raw_reason : 6'd0;
                    end
                    if (scan_idx_reg < n_use) begin
                        rd_en = 1'b1;
                    end else if (!p_valid_reg) begin
                        rpt_end    = 1'b1;
                        state_next = rem_int_reg ? rte_pkg::ST_HDR : rte_pkg::ST_DRAIN;
                    end
                end
            end
            rte_pkg::ST_DRAIN: begin
                if (can_push || !held_valid_reg) begin
                    drain_push = held_valid_reg;
                    state_next = rte_pkg::ST_IDLE;
                end
            end
            default: state_next = rte_pkg::ST_IDLE;
        endcase
    end

    assign emit_take = emit_en && (cnt_reg < rte_pkg::CntW'(rte_pkg::ResultLimit));
    assign push_held = (emit_take && held_valid_reg) || drain_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rte_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg         <= 1'b0;
            options_reg        <= '0;
            period_reg         <= '0;
            buftime_reg        <= '0;
            count_reg          <= 5'd1;
            incl_reason_reg    <= 1'b0;
            change_pending_reg <= 1'b0;
            gi_pending_reg     <= 1'b0;
            deadline_reg       <= '0;
            next_int_reg       <= '0;
            seq_reg            <= '0;
            toe_reg            <= '0;
            flag_valid_reg     <= '0;
            rem_int_reg        <= 1'b0;
            cnt_reg            <= '0;
            p_valid_reg        <= 1'b0;
            held_valid_reg     <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            // event intake
            if (upd_ok) begin
                flag_valid_reg[wr_addr] <= 1'b1;
                if (!change_pending_reg) begin
                    toe_reg      <= in_now;
                    deadline_reg <= 48'(in_now + {16'd0, buftime_reg});
                end
                change_pending_reg <= 1'b1;
            end
            if (in_acc && enable_reg && (in_mode == rte_pkg::MODE_GI)) begin
                gi_pending_reg <= 1'b1;
            end
            if (tick_go) begin
                if (do_gi || do_int) begin
                    toe_reg <= in_now;
                end
                if (do_int) begin
                    next_int_reg <= 48'(in_now + {16'd0, period_reg});
                end
                if (do_gi) begin
                    gi_pending_reg <= 1'b0;
                end
                change_pending_reg <= 1'b0;
                cnt_reg            <= '0;
                rem_int_reg        <= do_gi && do_int;
                cause_reg          <= do_gi  ? rte_pkg::CAUSE_GI :
                                      do_int ? rte_pkg::CAUSE_INTEGRITY :
                                               rte_pkg::CAUSE_CHANGE;
            end

            // scan walk
            if (hdr_go) begin
                scan_idx_reg <= '0;
                p_valid_reg  <= 1'b0;
            end
            if (state_reg == rte_pkg::ST_SCAN && adv) begin
                p_valid_reg <= rd_en;
                if (rd_en) begin
                    p_idx_reg    <= scan_idx_reg;
                    scan_idx_reg <= scan_idx_reg + 5'd1;
                end
            end
            if (rpt_end) begin
                flag_valid_reg <= '0;
                seq_reg        <= seq_reg + 16'd1;
                if (rem_int_reg) begin
                    cause_reg   <= rte_pkg::CAUSE_INTEGRITY;
                    rem_int_reg <= 1'b0;
                end
            end

            // holding and output registers
            if (emit_take) begin
                cnt_reg        <= cnt_reg + 1'b1;
                held_reg       <= emit_res;
                held_valid_reg <= 1'b1;
            end else if (drain_push) begin
                held_valid_reg <= 1'b0;
            end
            if (push_held) begin
                m_tvalid_reg <= 1'b1;
                out_reg      <= held_reg;
                m_tlast_reg  <= drain_push;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    rte_pkg::REG_ENABLE: begin
                        enable_reg     <= pwdata[0];
                        flag_valid_reg <= '0;
                        seq_reg        <= '0;
                    end
                    rte_pkg::REG_OPTIONS:   options_reg     <= pwdata[1:0];
                    rte_pkg::REG_INTEGRITY: period_reg      <= pwdata;
                    rte_pkg::REG_BUFTIME:   buftime_reg     <= pwdata;
                    rte_pkg::REG_COUNT:     count_reg       <= pwdata[4:0];
                    rte_pkg::REG_REASON:    incl_reason_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // entry flag memory
    always_ff @(posedge aclk) begin
        if (upd_ok) begin
            flag_mem[wr_addr] <= in_reason;
        end
        if (rd_en) begin
            rd_data_reg  <= flag_mem[rd_addr];
            rd_valid_reg <= flag_valid_reg[rd_addr];
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rte_pkg::REG_ENABLE:    prdata = {31'd0, enable_reg};
            rte_pkg::REG_OPTIONS:   prdata = {30'd0, options_reg};
            rte_pkg::REG_INTEGRITY: prdata = period_reg;
            rte_pkg::REG_BUFTIME:   prdata = buftime_reg;
            rte_pkg::REG_COUNT:     prdata = {27'd0, count_reg};
            rte_pkg::REG_REASON:    prdata = {31'd0, incl_reason_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {5'd0, out_reg.reason, out_reg.idx, out_reg.etime, out_reg.seq};
    assign m_tuser  = {out_reg.cause, out_reg.kind};

    a_idle_holds_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !held_valid_reg)
        else $error("holding register busy while accepting events");

    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rte_pkg::CntW'(rte_pkg::ResultLimit))
        else $error("result count beyond limit");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rte_pkg::ST_SCAN) |-> (scan_idx_reg <= n_use))
        else $error("scan index past entries in use");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (seq_reg != $past(seq_reg)))
        |-> ((seq_reg == 16'($past(seq_reg) + 16'd1)) || (seq_reg == 16'd0)))
        else $error("sequence number jumped");

endmodule

### tb/report_check_pkg.sv
// Expected-report generator and result checker for the report trigger engine testbench.
package report_check_pkg;

    localparam logic [1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic                 last;
        rte_pkg::rte_result_t body;
    } report_item_t;

    class report_predictor;
        logic        enable;
        logic [1:0]  options;
        logic [31:0] period;
        logic [31:0] buffer_ms;
        logic [4:0]  count;
        logic        with_reason;

        logic [1:0]  flags [rte_pkg::DefMaxEntries];
        logic        change_pending;
        logic        gi_pending;
        logic [47:0] deadline;
        logic [47:0] next_integrity;
        logic [15:0] seq;
        logic [47:0] stamp;

        report_item_t expected_items[$];
        report_item_t held;
        bit           have_held;
        int           emitted;
        int           mismatches;

        function new();
            reset_state();
            mismatches = 0;
        endfunction

        function void reset_state();
            enable = 1'b0;
            options = 2'd0;
            period = '0;
            buffer_ms = '0;
            count = 5'd1;
            with_reason = 1'b0;
            foreach (flags[i]) flags[i] = rte_pkg::WHY_NONE;
            change_pending = 1'b0;
            gi_pending = 1'b0;
            deadline = '0;
            next_integrity = '0;
            seq = '0;
            stamp = '0;
            have_held = 0;
            expected_items.delete();
        endfunction

        function void write_register(logic [2:0] sel, logic [31:0] value);
            case (sel)
                rte_pkg::REG_ENABLE: begin
                    enable = value[0];
                    foreach (flags[i]) flags[i] = rte_pkg::WHY_NONE;
                    seq = '0;
                end
                rte_pkg::REG_OPTIONS:   options = value[1:0];
                rte_pkg::REG_INTEGRITY: period = value;
                rte_pkg::REG_BUFTIME:   buffer_ms = value;
                rte_pkg::REG_COUNT:     count = value[4:0];
                rte_pkg::REG_REASON:    with_reason = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned entries_in_use();
            return (count > rte_pkg::DefMaxEntries) ? rte_pkg::DefMaxEntries : count;
        endfunction

        function logic [5:0] reason_of(logic [1:0] flag);
            case (flag)
                rte_pkg::WHY_QUALITY: return rte_pkg::BIT_QUALITY;
                rte_pkg::WHY_VALUE:   return rte_pkg::BIT_VALUE;
                rte_pkg::WHY_UPDATED: return rte_pkg::BIT_UPDATE;
                default:              return 6'd0;
            endcase
        endfunction

        // hold back the newest item so the final one can carry last
        function void emit(logic kind, logic [1:0] cause, logic [4:0] idx, logic [5:0] why);
            report_item_t item;
            if (emitted >= rte_pkg::ResultLimit) return;
            item.last = 1'b0;
            item.body.kind = kind;
            item.body.cause = cause;
            item.body.seq = seq;
            item.body.etime = stamp;
            item.body.idx = idx;
            item.body.reason = why;
            if (have_held) expected_items.push_back(held);
            held = item;
            have_held = 1;
            emitted++;
        endfunction

        function void send_report(logic [1:0] cause);
            int unsigned n;
            logic [5:0]  why;
            n = entries_in_use();
            emit(1'b0, cause, 5'd0, 6'd0);
            for (int unsigned i = 0; i < n; i++) begin
                if (cause == rte_pkg::CAUSE_GI) begin
                    why = rte_pkg::REASON_GI;
                end else if (cause == rte_pkg::CAUSE_INTEGRITY) begin
                    why = rte_pkg::REASON_INTEGRITY;
                end else begin
                    if (flags[i] == rte_pkg::WHY_NONE) continue;
                    why = reason_of(flags[i]);
                end
                emit(1'b1, cause, 5'(i), with_reason ? why : 6'd0);
            end
            foreach (flags[i]) flags[i] = rte_pkg::WHY_NONE;
            seq = seq + 16'd1;
            change_pending = 1'b0;
        endfunction

        function void absorb_event(logic [1:0] mode, logic [4:0] idx, logic [1:0] why,
                                   logic [47:0] now);
            emitted = 0;
            have_held = 0;
            if (!enable) return;
            case (mode)
                rte_pkg::MODE_UPDATE: begin
                    if (idx < entries_in_use()) begin
                        flags[idx] = why;
                        if (!change_pending) begin
                            stamp = now;
                            deadline = now + {16'd0, buffer_ms};
                        end
                        change_pending = 1'b1;
                    end
                end
                rte_pkg::MODE_GI: gi_pending = 1'b1;
                rte_pkg::MODE_TICK: begin
                    if (options[1] && gi_pending) begin
                        stamp = now;
                        send_report(rte_pkg::CAUSE_GI);
                        gi_pending = 1'b0;
                    end
                    if (options[0] && period != 0 && now >= next_integrity) begin
                        next_integrity = now + {16'd0, period};
                        stamp = now;
                        send_report(rte_pkg::CAUSE_INTEGRITY);
                    end
                    if (change_pending && now >= deadline)
                        send_report(rte_pkg::CAUSE_CHANGE);
                end
                default: ;
            endcase
            if (have_held) begin
                held.last = 1'b1;
                expected_items.push_back(held);
                have_held = 0;
            end
        endfunction

        function int outstanding();
            return expected_items.size();
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_report_item(report_item_t got);
            report_item_t want;
            if (expected_items.size() == 0) begin
                $error("unexpected request: kind %0d cause %0d seq 0x%0h index %0d",
                       got.body.kind, got.body.cause, got.body.seq, got.body.idx);
                mismatches++;
                return;
            end
            want = expected_items.pop_front();
            compare("kind", 64'(want.body.kind), 64'(got.body.kind));
            compare("cause", 64'(want.body.cause), 64'(got.body.cause));
            compare("sequence_number", 64'(want.body.seq), 64'(got.body.seq));
            compare("entry_time", 64'(want.body.etime), 64'(got.body.etime));
            compare("item_index", 64'(want.body.idx), 64'(got.body.idx));
            compare("reason_bits", 64'(want.body.reason), 64'(got.body.reason));
            compare("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

endpackage

### tb/testbench.sv
// Top-level testbench for report_trigger_engine: stream and APB drivers, phases, final verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE      = 60;
    localparam int HOLD_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    report_check_pkg::report_predictor predictor = new();

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requested = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic [47:0] now_ms_q = '0;
    int unsigned tick_reach = 30;
    logic [4:0]  cfg_count = 5'd1;
    int unsigned events_posted = 0;

    report_trigger_engine dut (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            predictor.check_report_item({m_tlast, m_tdata[74:69], m_tdata[68:64],
                                         m_tdata[63:16], m_tdata[15:0], m_tuser[2:1],
                                         m_tuser[0]});
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requested) begin
            hold_served <= hold_requested;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic post_event(input logic [1:0] mode, input logic [4:0] idx,
                              input logic [1:0] why, input logic [47:0] at);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {1'b0, at, why, idx};
        do @(posedge aclk); while (!s_tready);
        predictor.absorb_event(mode, idx, why, at);
        events_posted++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [2:0] sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        predictor.write_register(sel, value);
    endtask

    task automatic configure(input logic en, input logic [1:0] opts, input logic [31:0] period,
                             input logic [31:0] buffer_ms, input logic [4:0] count,
                             input logic why_on);
        write_reg(rte_pkg::REG_ENABLE, {31'd0, en});
        write_reg(rte_pkg::REG_OPTIONS, {30'd0, opts});
        write_reg(rte_pkg::REG_INTEGRITY, period);
        write_reg(rte_pkg::REG_BUFTIME, buffer_ms);
        write_reg(rte_pkg::REG_COUNT, {27'd0, count});
        write_reg(rte_pkg::REG_REASON, {31'd0, why_on});
        psel <= 1'b0;
        penable <= 1'b0;
        cfg_count = count;
    endtask

    // wait out every expected request, then the tail of any report in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        while (predictor.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic step_clock(input int unsigned reach);
        if ($urandom_range(29) == 0)
            now_ms_q = now_ms_q + 48'({$urandom, $urandom});
        else
            now_ms_q = now_ms_q + 48'($urandom_range(0, reach));
    endtask

    function automatic logic [4:0] pick_index();
        int unsigned span;
        span = (cfg_count > rte_pkg::DefMaxEntries) ? rte_pkg::DefMaxEntries : cfg_count;
        if (span == 0 || $urandom_range(7) == 0) return 5'($urandom_range(0, 30));
        return 5'($urandom_range(0, span - 1));
    endfunction

    task automatic run_burst();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            step_clock(3);
            post_event(rte_pkg::MODE_UPDATE, pick_index(), 2'($urandom_range(0, 3)),
                       now_ms_q);
        end
        if ($urandom_range(3) == 0) begin
            step_clock(2);
            post_event(rte_pkg::MODE_GI, 5'($urandom_range(0, 30)),
                       2'($urandom_range(0, 3)), now_ms_q);
        end
        n = $urandom_range(1, 2);
        repeat (n) begin
            step_clock(tick_reach);
            post_event(rte_pkg::MODE_TICK, 5'($urandom_range(0, 30)),
                       2'($urandom_range(0, 3)), now_ms_q);
        end
    endtask

    task automatic run_noise();
        if ($urandom_range(9) == 0)
            now_ms_q = 48'({$urandom, $urandom});
        else
            step_clock(20);
        post_event(2'($urandom_range(0, 3)), 5'($urandom_range(0, 30)),
                   2'($urandom_range(0, 3)), now_ms_q);
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned start;
        start = events_posted;
        while (events_posted - start < quota) begin
            if ($urandom_range(4) == 0)
                run_noise();
            else
                run_burst();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ignored while disabled
        post_event(rte_pkg::MODE_UPDATE, 5'd0, rte_pkg::WHY_VALUE, 48'd0);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd1);
        s_tvalid <= 1'b0;
        configure(1'b1, 2'b11, 32'd100, 32'd10, 5'd16, 1'b1);

        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd0);
        post_event(rte_pkg::MODE_UPDATE, 5'd0, rte_pkg::WHY_QUALITY, 48'd2);
        post_event(rte_pkg::MODE_UPDATE, 5'd15, rte_pkg::WHY_UPDATED, 48'd3);
        post_event(rte_pkg::MODE_UPDATE, 5'd16, rte_pkg::WHY_VALUE, 48'd3);
        post_event(rte_pkg::MODE_UPDATE, 5'd30, rte_pkg::WHY_QUALITY, 48'd3);
        post_event(rte_pkg::MODE_UPDATE, 5'd7, rte_pkg::WHY_VALUE, 48'd4);
        post_event(rte_pkg::MODE_UPDATE, 5'd7, rte_pkg::WHY_NONE, 48'd4);
        post_event(report_check_pkg::MODE_RESERVED, 5'd1, rte_pkg::WHY_VALUE, 48'd5);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd11);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd12);
        post_event(rte_pkg::MODE_UPDATE, 5'd5, rte_pkg::WHY_NONE, 48'd20);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd30);
        post_event(rte_pkg::MODE_GI, 5'd0, rte_pkg::WHY_NONE, 48'd31);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd32);
        post_event(rte_pkg::MODE_UPDATE, 5'd3, rte_pkg::WHY_VALUE, 48'd40);
        post_event(rte_pkg::MODE_GI, 5'd0, rte_pkg::WHY_NONE, 48'd101);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd200);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'hFFFF_FFFF_FFF0);
        post_event(rte_pkg::MODE_UPDATE, 5'd15, rte_pkg::WHY_UPDATED, 48'hFFFF_FFFF_FFFF);
        post_event(rte_pkg::MODE_TICK, 5'd0, rte_pkg::WHY_NONE, 48'd9);
        drain();
        now_ms_q = 48'd1000;

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    configure(1'b1, 2'b11, 32'd50, 32'd10, 5'd16, 1'b1);
                    tick_reach = 30;
                end
                1: begin
                    configure(1'b1, 2'b01, 32'd0, 32'd0, 5'd31, 1'b0);
                    tick_reach = 10;
                end
                2: begin
                    configure(1'b1, 2'b10, 32'd30, 32'd25, 5'd0, 1'b1);
                    tick_reach = 60;
                end
                3: begin
                    configure(1'b1, 2'b00, 32'd20, 32'hFFFF_FFFF, 5'd1, 1'b1);
                    tick_reach = 40;
                end
                4: begin
                    configure(1'b0, 2'b11, 32'd10, 32'd5, 5'd8, 1'b1);
                    tick_reach = 20;
                end
                5: begin
                    configure(1'b1, 2'b11, 32'hFFFF_FFFF, 32'd5,
                              5'($urandom_range(2, 15)), 1'b1);
                    tick_reach = 20;
                end
                6: begin
                    configure(1'b1, 2'b11, $urandom_range(1, 60), $urandom_range(0, 40),
                              5'd16, 1'b1);
                    tick_reach = 80;
                end
                default: begin
                    configure(1'b1, 2'b11, 32'd15, 32'd8, 5'($urandom_range(1, 31)),
                              1'($urandom_range(0, 1)));
                    tick_reach = 40;
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            case (p)
                2: begin
                    run_phase(25);
                    drain();
                    run_phase(25);
                end
                4: run_phase(8);
                6: begin
                    run_phase(10);
                    hold_requested++;
                    run_phase(40);
                end
                default: run_phase(45);
            endcase
            drain();
        end

        if (predictor.mismatches == 0)
            $display("report_trigger_engine verification clean");
        else
            $display("report_trigger_engine verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("report_trigger_engine verification failed");
        $finish;
    end

endmodule
